@@ rtl/wpa_pkg.sv @@
// ----------------------------------------------------------------------------
// wpa_pkg
// Shared types and constants of the weighted pixel accumulator.
// ----------------------------------------------------------------------------
package wpa_pkg;

  localparam int unsigned MaxWidthDefault  = 1280;
  localparam int unsigned MaxHeightDefault = 720;

  localparam int unsigned XW   = 11;
  localparam int unsigned YW   = 10;
  localparam int unsigned CW   = 16;
  localparam int unsigned SW   = 32;
  localparam int unsigned QD   = 4;
  localparam int unsigned IW   = 25;

  localparam logic [1:0] CmdAdd   = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;
  localparam logic [1:0] CmdNop   = 2'd3;

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef enum logic [1:0] {
    OpAdd,
    OpRead,
    OpClear
  } op_e;

  // classified word passed from front to back; index width is fixed at 25
  // bits, which covers 4096 x 4096
  typedef struct packed {
    op_e           op;
    logic          in_area;
    logic [IW-1:0] index;
    logic [IW-1:0] count;
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
    logic [CW-1:0] weight;
  } op_t;

  typedef struct packed {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
    logic          zero_weight;
    logic          overflowed;
  } res_t;

endpackage

@@ rtl/wpa_front.sv @@
// ----------------------------------------------------------------------------
// wpa_front
// Accepts commands, holds configuration, computes pixel index and bounds.
// Two stages: multiply and width/height check, then index sum and depth check.
// ----------------------------------------------------------------------------
module wpa_front #(
  parameter int unsigned MaxWidth  = wpa_pkg::MaxWidthDefault,
  parameter int unsigned MaxHeight = wpa_pkg::MaxHeightDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [wpa_pkg::XW-1:0] cfg_data_i,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [1:0]            command_i,
  input  logic [wpa_pkg::XW-1:0] pixel_x_i,
  input  logic [wpa_pkg::YW-1:0] pixel_y_i,
  input  logic [wpa_pkg::CW-1:0] sample_red_i,
  input  logic [wpa_pkg::CW-1:0] sample_green_i,
  input  logic [wpa_pkg::CW-1:0] sample_blue_i,
  input  logic [wpa_pkg::CW-1:0] sample_weight_i,
  output logic                  op_valid_o,
  input  logic                  op_ready_i,
  output wpa_pkg::op_t          op_o
);

  localparam logic [wpa_pkg::IW-1:0] Depth = wpa_pkg::IW'(MaxWidth * MaxHeight);

  logic [wpa_pkg::XW-1:0] width_q;
  logic [wpa_pkg::YW-1:0] height_q;

  logic                   s1_valid_q;
  logic [1:0]             s1_cmd_q;
  logic                   s1_in_q;
  logic [21:0]            s1_prod_q;
  logic [20:0]            s1_area_q;
  logic [wpa_pkg::XW-1:0] s1_x_q;
  logic [wpa_pkg::CW-1:0] s1_r_q, s1_g_q, s1_b_q, s1_w_q;
  logic                   s2_valid_q;
  wpa_pkg::op_t           s2_q;
  wpa_pkg::op_t           s2_d;
  logic                   s2_free, s1_adv, take;
  logic [wpa_pkg::IW-1:0] idx;

  assign s2_free = !s2_valid_q || op_ready_i;
  assign s1_adv  = s1_valid_q && s2_free;
  assign full_o  = s1_valid_q && !s2_free;
  assign take    = push_i && !full_o;

  always_comb begin
    idx = wpa_pkg::IW'(s1_x_q) + wpa_pkg::IW'(s1_prod_q);
    s2_d = '0;
    s2_d.in_area = s1_in_q && (idx < Depth);
    s2_d.index   = idx;
    s2_d.count   = (wpa_pkg::IW'(s1_area_q) > Depth) ? Depth : wpa_pkg::IW'(s1_area_q);
    s2_d.red     = s1_r_q;
    s2_d.green   = s1_g_q;
    s2_d.blue    = s1_b_q;
    s2_d.weight  = s1_w_q;
    case (s1_cmd_q)
      wpa_pkg::CmdAdd:  s2_d.op = wpa_pkg::OpAdd;
      wpa_pkg::CmdRead: s2_d.op = wpa_pkg::OpRead;
      default:          s2_d.op = wpa_pkg::OpClear;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= wpa_pkg::XW'(1280);
      height_q   <= wpa_pkg::YW'(720);
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == wpa_pkg::CfgWidth) width_q <= cfg_data_i;
        else height_q <= cfg_data_i[wpa_pkg::YW-1:0];
      end
      if (s2_free) s2_valid_q <= s1_adv;
      if (!full_o) s1_valid_q <= take && (command_i != wpa_pkg::CmdNop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_cmd_q  <= command_i;
      s1_in_q   <= (pixel_x_i < width_q) && (pixel_y_i < height_q);
      s1_prod_q <= 22'(width_q) * 22'(pixel_y_i);
      s1_area_q <= 21'(width_q) * 21'(height_q);
      s1_x_q    <= pixel_x_i;
      s1_r_q    <= sample_red_i;
      s1_g_q    <= sample_green_i;
      s1_b_q    <= sample_blue_i;
      s1_w_q    <= sample_weight_i;
    end
    if (s1_adv) s2_q <= s2_d;
  end

  assign op_valid_o = s2_valid_q;
  assign op_o       = s2_q;

endmodule

@@ rtl/wpa_queue.sv @@
// ----------------------------------------------------------------------------
// wpa_queue
// Small first-in first-out queue of words between front and back.
// ----------------------------------------------------------------------------
module wpa_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);

  localparam int unsigned Aw = $clog2(wpa_pkg::QD);

  logic [Width-1:0] mem_q [wpa_pkg::QD];
  logic [Aw-1:0]    wp_q, rp_q;
  logic [Aw:0]      cnt_q;
  logic             wr, rd;

  assign wr_ready_o = cnt_q != (Aw+1)'(wpa_pkg::QD);
  assign rd_valid_o = cnt_q != '0;
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(wr) - (Aw+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

@@ rtl/wpa_div.sv @@
// ----------------------------------------------------------------------------
// wpa_div
// Restoring divider, one quotient bit a cycle: floor(num * 256 / den),
// saturated to 16 bits. Quotient bits from bit 16 up only flag saturation.
// ----------------------------------------------------------------------------
module wpa_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [wpa_pkg::SW-1:0] num_i,
  input  logic [wpa_pkg::SW-1:0] den_i,
  output logic                   done_o,
  output logic [wpa_pkg::CW-1:0] quo_o,
  output logic                   sat_o
);

  logic [39:0] num_q;
  logic [32:0] rem_q;
  logic [31:0] den_q;
  logic [16:0] quo_q;
  logic        hi_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [32:0] shl;
  logic [33:0] dif;

  assign shl = {rem_q[31:0], num_q[39]};
  assign dif = {1'b0, shl} - {2'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd40;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {num_i, 8'd0};
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      hi_q  <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[38:0], 1'b0};
      hi_q  <= hi_q | quo_q[16];
      if (!dif[33]) begin
        rem_q <= dif[32:0];
        quo_q <= {quo_q[15:0], 1'b1};
      end else begin
        rem_q <= shl;
        quo_q <= {quo_q[15:0], 1'b0};
      end
    end
  end

  assign sat_o = hi_q | quo_q[16];
  assign quo_o = sat_o ? '1 : quo_q[15:0];

endmodule

@@ rtl/wpa_back.sv @@
// ----------------------------------------------------------------------------
// wpa_back
// Executes queued operations against the film memory: add read-modify-write,
// resolve via a shared divider, and clear sweeps. Also the power-on clear.
// ----------------------------------------------------------------------------
module wpa_back #(
  parameter int unsigned MaxWidth  = wpa_pkg::MaxWidthDefault,
  parameter int unsigned MaxHeight = wpa_pkg::MaxHeightDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   op_valid_i,
  output logic                   op_ready_o,
  input  wpa_pkg::op_t           op_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output wpa_pkg::res_t          res_o
);

  localparam int unsigned Depth = MaxWidth * MaxHeight;
  localparam int unsigned Aw    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned EntW  = 4 * wpa_pkg::SW + 1;

  typedef enum logic [3:0] {
    StInit, StIdle, StAddRd, StAddWr, StRdRd, StDivR, StDivG, StDivB, StOut, StClr
  } state_e;

  state_e          state_q;
  logic [EntW-1:0] mem_q [Depth];
  logic [EntW-1:0] rdata_q;
  logic [wpa_pkg::IW-1:0] ptr_q;
  logic [wpa_pkg::IW-1:0] end_q;
  wpa_pkg::op_t    cur_q;
  wpa_pkg::res_t   res_q;
  logic            res_v_q;
  logic            we;
  logic [Aw-1:0]   waddr, raddr;
  logic [EntW-1:0] wdata;
  logic            div_start, div_done, div_sat;
  logic [wpa_pkg::CW-1:0] div_q;
  logic [wpa_pkg::SW-1:0] div_num;
  logic [32:0]     sr, sg, sb, sw;
  logic            ovf;
  logic [wpa_pkg::SW-1:0] e_r, e_g, e_b, e_w;

  assign e_r = rdata_q[EntW-1 -: 32];
  assign e_g = rdata_q[EntW-33 -: 32];
  assign e_b = rdata_q[EntW-65 -: 32];
  assign e_w = rdata_q[EntW-97 -: 32];

  assign sr  = {1'b0, e_r} + 33'(cur_q.red);
  assign sg  = {1'b0, e_g} + 33'(cur_q.green);
  assign sb  = {1'b0, e_b} + 33'(cur_q.blue);
  assign sw  = {1'b0, e_w} + 33'(cur_q.weight);
  assign ovf = sr[32] | sg[32] | sb[32] | sw[32];

  always_comb begin
    we    = 1'b0;
    waddr = ptr_q[Aw-1:0];
    wdata = '0;
    if (state_q == StInit || state_q == StClr) begin
      we = 1'b1;
    end else if (state_q == StAddWr) begin
      we    = 1'b1;
      waddr = cur_q.index[Aw-1:0];
      wdata = {sr[32] ? 32'hFFFF_FFFF : sr[31:0], sg[32] ? 32'hFFFF_FFFF : sg[31:0],
               sb[32] ? 32'hFFFF_FFFF : sb[31:0], sw[32] ? 32'hFFFF_FFFF : sw[31:0],
               rdata_q[0] | ovf};
    end
  end

  assign raddr = cur_q.index[Aw-1:0];

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  assign div_start = (state_q == StRdRd && e_w != '0) ||
                     (div_done && (state_q == StDivR || state_q == StDivG));
  always_comb begin
    case (state_q)
      StDivR:  div_num = e_g;
      StDivG:  div_num = e_b;
      default: div_num = e_r;
    endcase
  end

  wpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (e_w),
    .done_o (div_done),
    .quo_o  (div_q),
    .sat_o  (div_sat)
  );

  assign op_ready_o  = state_q == StIdle && !res_v_q;
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      ptr_q   <= '0;
      end_q   <= wpa_pkg::IW'(Depth);
      res_v_q <= 1'b0;
    end else begin
      if (res_v_q && res_ready_i) res_v_q <= 1'b0;
      unique case (state_q)
        StInit, StClr: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q + 1'b1 >= end_q) state_q <= StIdle;
        end
        StIdle: begin
          if (op_valid_i && op_ready_o) begin
            cur_q <= op_i;
            unique case (op_i.op)
              wpa_pkg::OpAdd:  if (op_i.in_area) state_q <= StAddRd;
              wpa_pkg::OpRead: begin
                res_q <= '{red: '0, green: '0, blue: '0, zero_weight: 1'b1,
                           overflowed: 1'b0};
                if (op_i.in_area) state_q <= StAddRd;
                else res_v_q <= 1'b1;
              end
              default: begin
                ptr_q <= '0;
                end_q <= op_i.count;
                if (op_i.count != '0) state_q <= StClr;
              end
            endcase
          end
        end
        StAddRd: state_q <= (cur_q.op == wpa_pkg::OpAdd) ? StAddWr : StRdRd;
        StAddWr: state_q <= StIdle;
        StRdRd: begin
          res_q.overflowed <= rdata_q[0];
          if (e_w == '0) begin
            state_q <= StOut;
          end else begin
            res_q.zero_weight <= 1'b0;
            state_q <= StDivR;
          end
        end
        StDivR: if (div_done) begin
          res_q.red <= div_q;
          res_q.overflowed <= res_q.overflowed | div_sat;
          state_q <= StDivG;
        end
        StDivG: if (div_done) begin
          res_q.green <= div_q;
          res_q.overflowed <= res_q.overflowed | div_sat;
          state_q <= StDivB;
        end
        StDivB: if (div_done) begin
          res_q.blue <= div_q;
          res_q.overflowed <= res_q.overflowed | div_sat;
          state_q <= StOut;
        end
        StOut: begin
          res_v_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

@@ rtl/weighted_pixel_accumulator.sv @@
// ----------------------------------------------------------------------------
// weighted_pixel_accumulator
// Film store accumulating weighted color samples per pixel, with resolve.
// ----------------------------------------------------------------------------
// An add runs in the back end as accept, memory read, then write. A read of a
// weighted pixel runs three 40-step serial divisions that share one divider;
// a read of a zero-weight pixel or of a pixel outside the area skips the
// divider. A clear writes active_width*active_height entries (at most the
// store size), one entry a cycle. After reset a clear pass over all
// MaxWidth*MaxHeight entries runs before commands are executed; commands queue
// up meanwhile. The front end takes one word a cycle until the short queue
// behind it and its own stages fill.
module weighted_pixel_accumulator #(
  parameter int unsigned MaxWidth  = wpa_pkg::MaxWidthDefault,
  parameter int unsigned MaxHeight = wpa_pkg::MaxHeightDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [wpa_pkg::XW-1:0] cfg_data_i,
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             command_i,
  input  logic [wpa_pkg::XW-1:0] pixel_x_i,
  input  logic [wpa_pkg::YW-1:0] pixel_y_i,
  input  logic [wpa_pkg::CW-1:0] sample_red_i,
  input  logic [wpa_pkg::CW-1:0] sample_green_i,
  input  logic [wpa_pkg::CW-1:0] sample_blue_i,
  input  logic [wpa_pkg::CW-1:0] sample_weight_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [wpa_pkg::CW-1:0] out_red_o,
  output logic [wpa_pkg::CW-1:0] out_green_o,
  output logic [wpa_pkg::CW-1:0] out_blue_o,
  output logic                   zero_weight_o,
  output logic                   overflowed_o
);

  logic          f_valid, f_ready, b_valid, b_ready, r_valid, r_ready, o_valid;
  wpa_pkg::op_t  f_op, b_op;
  wpa_pkg::res_t r_res, o_res;

  wpa_front #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .push_i(push), .full_o(full), .command_i, .pixel_x_i, .pixel_y_i,
    .sample_red_i, .sample_green_i, .sample_blue_i, .sample_weight_i,
    .op_valid_o(f_valid), .op_ready_i(f_ready), .op_o(f_op)
  );

  wpa_queue #(.Width($bits(wpa_pkg::op_t))) u_opq (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_op),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_op)
  );

  wpa_back #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_back (
    .clk_i, .rst_ni,
    .op_valid_i(b_valid), .op_ready_o(b_ready), .op_i(b_op),
    .res_valid_o(r_valid), .res_ready_i(r_ready), .res_o(r_res)
  );

  wpa_queue #(.Width($bits(wpa_pkg::res_t))) u_resq (
    .clk_i, .rst_ni,
    .wr_valid_i(r_valid), .wr_ready_o(r_ready), .wr_data_i(r_res),
    .rd_valid_o(o_valid), .rd_ready_i(pop), .rd_data_o(o_res)
  );

  assign empty         = !o_valid;
  assign out_red_o     = o_res.red;
  assign out_green_o   = o_res.green;
  assign out_blue_o    = o_res.blue;
  assign zero_weight_o = o_res.zero_weight;
  assign overflowed_o  = o_res.overflowed;

endmodule
